// ===== hw/rtl/adsr_env_pkg.sv =====
// ----------------------------------------------------------------------------
// ADSR attenuation envelope package
// Shared types, codes and widths for the envelope generator and its checker.
// ----------------------------------------------------------------------------
package adsr_env_pkg;

	localparam int LevelW = 4;
	localparam int RateW  = 8;
	localparam int PhaseW = 3;
	localparam int OpW    = 2;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 8;

	localparam logic [LevelW-1:0] LevelSilent = 4'd15;

	typedef enum logic [PhaseW-1:0] {
		PH_IDLE    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	typedef enum logic [OpW-1:0] {
		OP_TICK     = 2'd0,
		OP_NOTE_ON  = 2'd1,
		OP_NOTE_OFF = 2'd2
	} op_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ATTACK_RATE   = 3'd0,
		REG_DECAY_RATE    = 3'd1,
		REG_SUSTAIN_LEVEL = 3'd2,
		REG_SUSTAIN_RATE  = 3'd3,
		REG_RELEASE_RATE  = 3'd4,
		REG_DEFAULT_ATTN  = 3'd5
	} cfg_reg_t;

endpackage

// ===== hw/rtl/adsr_attenuation_envelope.sv =====
// ----------------------------------------------------------------------------
// ADSR attenuation envelope
// One-voice attack/decay/sustain/release envelope in 4-bit attenuation units.
// ----------------------------------------------------------------------------
// The block takes one event per clock cycle when not stalled (tick frame, note
// on, note off) and returns one result per event: the level, whether the voice
// sounds, and the phase after that event. The event is held in an input
// register, the envelope update runs as one short combinational pass, and the
// result lands in an output register once that register is empty or drains.
// While a result waits to be taken the input register can still take one more
// event; with that register full too the input stalls until the result is
// taken, so the sustained rate is one event per cycle with the downstream side
// ready. Configuration writes are always accepted and take effect on the next
// event; they are meant to be issued while no event is in flight.
module adsr_attenuation_envelope (
	input  logic                                clk,
	input  logic                                arst_n,
	// s_tdata: [3:0] note_attn, [7:4] zero
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,
	// s_tuser: [1:0] op, [2] use_default
	input  logic [2:0]                          s_tuser,
	// m_tdata: [3:0] level, [4] voice_active, [7:5] phase
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [adsr_env_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [adsr_env_pkg::CfgDataW-1:0]   cfg_data
);

	// Configuration registers
	logic [adsr_env_pkg::RateW-1:0]  attack_rate_q;
	logic [adsr_env_pkg::RateW-1:0]  decay_rate_q;
	logic [adsr_env_pkg::LevelW-1:0] sustain_level_q;
	logic [adsr_env_pkg::RateW-1:0]  sustain_rate_q;
	logic [adsr_env_pkg::RateW-1:0]  release_rate_q;
	logic [adsr_env_pkg::LevelW-1:0] default_attn_q;

	// Envelope state
	logic                            running_q, running_d;
	adsr_env_pkg::phase_t            phase_q, phase_d;
	logic [adsr_env_pkg::RateW-1:0]  count_q, count_d;
	logic [adsr_env_pkg::LevelW-1:0] level_q, level_d;
	logic [adsr_env_pkg::LevelW-1:0] base_q, base_d;

	// Input stage
	logic                            valid_s1;
	adsr_env_pkg::op_t               op_s1;
	logic [adsr_env_pkg::LevelW-1:0] note_attn_s1;
	logic                            use_default_s1;
	logic                            fire_s1;

	// Result register
	logic                            out_valid_q;
	logic [7:0]                      out_data_q;
	logic [7:0]                      out_data_d;

	logic [adsr_env_pkg::LevelW-1:0] sus;
	logic [adsr_env_pkg::LevelW-1:0] step_lvl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_rate_q   <= '0;
			decay_rate_q    <= '0;
			sustain_level_q <= '0;
			sustain_rate_q  <= '0;
			release_rate_q  <= '0;
			default_attn_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				adsr_env_pkg::REG_ATTACK_RATE:   attack_rate_q   <= cfg_data;
				adsr_env_pkg::REG_DECAY_RATE:    decay_rate_q    <= cfg_data;
				adsr_env_pkg::REG_SUSTAIN_LEVEL:
					sustain_level_q <= cfg_data[adsr_env_pkg::LevelW-1:0];
				adsr_env_pkg::REG_SUSTAIN_RATE:  sustain_rate_q  <= cfg_data;
				adsr_env_pkg::REG_RELEASE_RATE:  release_rate_q  <= cfg_data;
				adsr_env_pkg::REG_DEFAULT_ATTN:
					default_attn_q  <= cfg_data[adsr_env_pkg::LevelW-1:0];
				default: ;
			endcase
		end
	end

	// The input stage moves on when the result register is empty or drains now.
	assign fire_s1  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1          <= adsr_env_pkg::op_t'(s_tuser[1:0]);
			use_default_s1 <= s_tuser[2];
			note_attn_s1   <= s_tdata[adsr_env_pkg::LevelW-1:0];
		end
	end

	assign sus = (sustain_level_q > base_q) ? sustain_level_q : base_q;

	// Next envelope state for the event in the input stage.
	always_comb begin
		running_d = running_q;
		phase_d   = phase_q;
		count_d   = count_q;
		level_d   = level_q;
		base_d    = base_q;
		step_lvl  = level_q;
		case (op_s1)
			adsr_env_pkg::OP_NOTE_ON: begin
				running_d = 1'b1;
				base_d    = use_default_s1 ? default_attn_q : note_attn_s1;
				level_d   = adsr_env_pkg::LevelSilent;
				phase_d   = adsr_env_pkg::PH_ATTACK;
				count_d   = attack_rate_q;
			end
			adsr_env_pkg::OP_NOTE_OFF: begin
				if (release_rate_q != '0 && running_q) begin
					phase_d = adsr_env_pkg::PH_RELEASE;
					count_d = release_rate_q;
				end else begin
					phase_d   = adsr_env_pkg::PH_IDLE;
					running_d = 1'b0;
				end
			end
			adsr_env_pkg::OP_TICK: begin
				if (running_q) begin
					unique case (phase_q)
						adsr_env_pkg::PH_ATTACK: begin
							step_lvl = (level_q > base_q) ? level_q - 4'd1 : level_q;
							if (attack_rate_q == '0 ||
							    (count_q == '0 && step_lvl <= base_q)) begin
								level_d = base_q;
								phase_d = adsr_env_pkg::PH_DECAY;
								count_d = decay_rate_q;
							end else if (count_q == '0) begin
								level_d = step_lvl;
								count_d = attack_rate_q;
							end else begin
								count_d = count_q - 8'd1;
							end
						end
						adsr_env_pkg::PH_DECAY: begin
							step_lvl = (level_q < sus) ? level_q + 4'd1 : level_q;
							if (decay_rate_q == '0 || sus <= base_q ||
							    (count_q == '0 && step_lvl >= sus)) begin
								level_d = sus;
								phase_d = adsr_env_pkg::PH_SUSTAIN;
								count_d = sustain_rate_q;
							end else if (count_q == '0) begin
								level_d = step_lvl;
								count_d = decay_rate_q;
							end else begin
								count_d = count_q - 8'd1;
							end
						end
						adsr_env_pkg::PH_SUSTAIN,
						adsr_env_pkg::PH_RELEASE: begin
							// Sustain fade-out and release share the step toward silence.
							step_lvl = (level_q < adsr_env_pkg::LevelSilent) ?
							           level_q + 4'd1 : level_q;
							if (phase_q == adsr_env_pkg::PH_RELEASE &&
							    release_rate_q == '0) begin
								level_d   = adsr_env_pkg::LevelSilent;
								phase_d   = adsr_env_pkg::PH_IDLE;
								running_d = 1'b0;
							end else if (phase_q == adsr_env_pkg::PH_SUSTAIN &&
							             sustain_rate_q == '0) begin
								// A zero sustain rate holds the level.
							end else if (count_q == '0) begin
								level_d = step_lvl;
								if (step_lvl >= adsr_env_pkg::LevelSilent) begin
									phase_d   = adsr_env_pkg::PH_IDLE;
									running_d = 1'b0;
								end else begin
									count_d = (phase_q == adsr_env_pkg::PH_RELEASE) ?
									          release_rate_q : sustain_rate_q;
								end
							end else begin
								count_d = count_q - 8'd1;
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// Result packet built from the updated state.
	always_comb begin
		out_data_d = {phase_d, running_d, level_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			phase_q   <= adsr_env_pkg::PH_IDLE;
			count_q   <= '0;
			level_q   <= adsr_env_pkg::LevelSilent;
			base_q    <= '0;
		end else if (fire_s1) begin
			running_q <= running_d;
			phase_q   <= phase_d;
			count_q   <= count_d;
			level_q   <= level_d;
			base_q    <= base_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_data_q <= out_data_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== hw/rtl/adsr_env_chk.sv =====
// ----------------------------------------------------------------------------
// ADSR attenuation envelope checker
// Port-level assertions on the envelope generator, attached by bind.
// ----------------------------------------------------------------------------
module adsr_env_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [7:0]                        s_tdata,
	input logic [2:0]                        s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [7:0]                        m_tdata,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [adsr_env_pkg::CfgIdxW-1:0]  cfg_index,
	input logic [adsr_env_pkg::CfgDataW-1:0] cfg_data
);

	// A stalled result stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Input back-pressure only arises while a result is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with no pending result");

	// An accepted event reaches the output once the result register is free or drains.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 (!m_tvalid || m_tready) |=> m_tvalid)
		else $error("accepted event produced no result");

	// A sounding phase always reports an active voice.
	a_phase_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7:5] != adsr_env_pkg::PH_IDLE |-> m_tdata[4])
		else $error("non-idle phase with inactive voice");

endmodule

bind adsr_attenuation_envelope adsr_env_chk u_adsr_env_chk (.*);

// ===== sim/adsr_attenuation_envelope_tb.sv =====
// ----------------------------------------------------------------------------
// ADSR attenuation envelope testbench
// Drives note and tick events through the stream port, predicts results with
// a behavioral model or a typed-in table, and compares level, activity and phase.
// Register settings change between phases; idle and stall rates vary too.
// ----------------------------------------------------------------------------
module adsr_attenuation_envelope_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import adsr_env_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int NumPhases = 10;
	localparam int EventsPerPhase = 105;
	localparam int NumDirected = 26;
	localparam int DirGroupB = 13;
	localparam logic [OpW-1:0] OpUnused = 2'd3;

	typedef struct packed {
		logic [LevelW-1:0] lvl;
		logic              act;
		phase_t            ph;
	} env_result_t;

	typedef struct packed {
		logic [OpW-1:0]    op;
		logic [LevelW-1:0] attn;
		logic              ud;
		logic              typed;
		env_result_t       want;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = '0;
	logic [2:0]          s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [7:0]          m_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = REG_ATTACK_RATE;
	logic [CfgDataW-1:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int cycle_count = 0;

	// Register shadow and envelope state of the predictor.
	logic [RateW-1:0]  atk_rate = '0, dcy_rate = '0, sus_rate = '0, rel_rate = '0;
	logic [LevelW-1:0] sus_lvl = '0, dflt_attn = '0;
	logic              env_on = 1'b0;
	phase_t            env_ph = PH_IDLE;
	logic [RateW-1:0]  env_cnt = '0;
	logic [LevelW-1:0] env_lvl = LevelSilent;
	logic [LevelW-1:0] env_base = '0;

	env_result_t env_results_due [$];

	// The first group runs with the registers at reset and has its results
	// typed in; the second group is checked against the predictor.
	dir_row_t dir_rows [0:NumDirected-1] = '{
		'{OP_TICK,     4'd0,  1'b0, 1'b1, '{4'd15, 1'b0, PH_IDLE}},
		'{OpUnused,    4'd15, 1'b1, 1'b1, '{4'd15, 1'b0, PH_IDLE}},
		'{OP_NOTE_OFF, 4'd0,  1'b0, 1'b1, '{4'd15, 1'b0, PH_IDLE}},
		'{OP_NOTE_ON,  4'd0,  1'b0, 1'b1, '{4'd15, 1'b1, PH_ATTACK}},
		'{OP_TICK,     4'd0,  1'b0, 1'b1, '{4'd0,  1'b1, PH_DECAY}},
		'{OP_TICK,     4'd0,  1'b0, 1'b1, '{4'd0,  1'b1, PH_SUSTAIN}},
		'{OP_TICK,     4'd15, 1'b1, 1'b1, '{4'd0,  1'b1, PH_SUSTAIN}},
		'{OP_NOTE_ON,  4'd9,  1'b1, 1'b1, '{4'd15, 1'b1, PH_ATTACK}},
		'{OP_NOTE_OFF, 4'd0,  1'b0, 1'b1, '{4'd15, 1'b0, PH_IDLE}},
		'{OP_NOTE_ON,  4'd15, 1'b0, 1'b1, '{4'd15, 1'b1, PH_ATTACK}},
		'{OP_TICK,     4'd0,  1'b0, 1'b1, '{4'd15, 1'b1, PH_DECAY}},
		'{OP_TICK,     4'd0,  1'b0, 1'b1, '{4'd15, 1'b1, PH_SUSTAIN}},
		'{OP_NOTE_OFF, 4'd0,  1'b0, 1'b1, '{4'd15, 1'b0, PH_IDLE}},
		'{OP_NOTE_ON,  4'd5,  1'b0, 1'b0, '{4'd0,  1'b0, PH_IDLE}},
		'{OP_TICK,     4'd0,  1'b0, 1'b0, '{4'd0,  1'b0, PH_IDLE}},
		'{OP_TICK,     4'd0,  1'b0, 1'b0, '{4'd0,  1'b0, PH_IDLE}},
		'{OP_TICK,     4'd0,  1'b0, 1'b0, '{4'd0,  1'b0, PH_IDLE}},
		'{OP_TICK,     4'd0,  1'b0, 1'b0, '{4'd0,  1'b0, PH_IDLE}},
		'{OP_TICK,     4'd0,  1'b0, 1'b0, '{4'd0,  1'b0, PH_IDLE}},
		'{OP_TICK,     4'd0,  1'b0, 1'b0, '{4'd0,  1'b0, PH_IDLE}},
		'{OP_TICK,     4'd0,  1'b0, 1'b0, '{4'd0,  1'b0, PH_IDLE}},
		'{OP_NOTE_OFF, 4'd0,  1'b0, 1'b0, '{4'd0,  1'b0, PH_IDLE}},
		'{OP_TICK,     4'd0,  1'b0, 1'b0, '{4'd0,  1'b0, PH_IDLE}},
		'{OP_NOTE_ON,  4'd0,  1'b1, 1'b0, '{4'd0,  1'b0, PH_IDLE}},
		'{OP_TICK,     4'd0,  1'b0, 1'b0, '{4'd0,  1'b0, PH_IDLE}},
		'{OP_TICK,     4'd0,  1'b0, 1'b0, '{4'd0,  1'b0, PH_IDLE}}
	};

	adsr_attenuation_envelope dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("adsr_attenuation_envelope_tb failed");
			$finish;
		end
	end

	// Outputs are stable at the falling edge, so a transfer seen here is the
	// one completed at the next rising edge.
	always @(negedge clk) begin
		env_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (env_results_due.size() == 0) begin
				$error("result 0x%02h with no expected result pending", m_tdata);
				errors++;
			end else begin
				want = env_results_due.pop_front();
				if (m_tdata[3:0] !== want.lvl) begin
					$error("level: expected %0d, got %0d", want.lvl, m_tdata[3:0]);
					errors++;
				end
				if (m_tdata[4] !== want.act) begin
					$error("voice_active: expected %0d, got %0d", want.act, m_tdata[4]);
					errors++;
				end
				if (m_tdata[7:5] !== want.ph) begin
					$error("phase: expected %0d, got %0d", want.ph, m_tdata[7:5]);
					errors++;
				end
			end
		end
	end

	// One unit toward silence; the voice ends when it reaches silence.
	task automatic fade_toward_silence(input logic [RateW-1:0] rate);
		if (env_lvl < LevelSilent) env_lvl++;
		if (env_lvl >= LevelSilent) begin
			env_ph = PH_IDLE;
			env_on = 1'b0;
		end else begin
			env_cnt = rate;
		end
	endtask

	task automatic advance_envelope(input logic [OpW-1:0] op, input logic [LevelW-1:0] attn,
			input logic ud);
		logic [LevelW-1:0] sus;
		logic              dcy_on;
		sus = (sus_lvl > env_base) ? sus_lvl : env_base;
		dcy_on = (dcy_rate != 0) && (sus > env_base);
		case (op)
			OP_NOTE_ON: begin
				env_on = 1'b1;
				env_base = ud ? dflt_attn : attn;
				env_lvl = LevelSilent;
				env_ph = PH_ATTACK;
				env_cnt = atk_rate;
			end
			OP_NOTE_OFF: begin
				if (rel_rate != 0 && env_on) begin
					env_ph = PH_RELEASE;
					env_cnt = rel_rate;
				end else begin
					env_ph = PH_IDLE;
					env_on = 1'b0;
				end
			end
			OP_TICK: begin
				if (env_on) begin
					case (env_ph)
						PH_ATTACK: begin
							if (atk_rate != 0 && env_cnt != 0) begin
								env_cnt--;
							end else begin
								if (atk_rate != 0 && env_lvl > env_base) env_lvl--;
								if (atk_rate == 0 || env_lvl <= env_base) begin
									env_lvl = env_base;
									env_ph = PH_DECAY;
									env_cnt = dcy_rate;
								end else begin
									env_cnt = atk_rate;
								end
							end
						end
						PH_DECAY: begin
							if (dcy_on && env_cnt != 0) begin
								env_cnt--;
							end else begin
								if (dcy_on && env_lvl < sus) env_lvl++;
								if (!dcy_on || env_lvl >= sus) begin
									env_lvl = sus;
									env_ph = PH_SUSTAIN;
									env_cnt = sus_rate;
								end else begin
									env_cnt = dcy_rate;
								end
							end
						end
						PH_SUSTAIN: begin
							if (sus_rate != 0) begin
								if (env_cnt == 0) fade_toward_silence(sus_rate);
								else env_cnt--;
							end
						end
						PH_RELEASE: begin
							if (rel_rate == 0) begin
								env_lvl = LevelSilent;
								env_ph = PH_IDLE;
								env_on = 1'b0;
							end else if (env_cnt == 0) begin
								fade_toward_silence(rel_rate);
							end else begin
								env_cnt--;
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	endtask

	// Valid stays high from one event to the next; it is lowered only for a gap.
	task automatic push_event(input logic [OpW-1:0] op, input logic [LevelW-1:0] attn,
			input logic ud, input logic typed, input env_result_t want);
		logic rdy;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, attn};
		s_tuser <= {ud, op};
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		advance_envelope(op, attn, ud);
		if (typed) env_results_due.insert(env_results_due.size(), want);
		else env_results_due.insert(env_results_due.size(), '{env_lvl, env_on, env_ph});
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (env_results_due.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [CfgDataW-1:0] val);
		logic rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		case (idx)
			REG_ATTACK_RATE:   atk_rate = val;
			REG_DECAY_RATE:    dcy_rate = val;
			REG_SUSTAIN_LEVEL: sus_lvl = val[LevelW-1:0];
			REG_SUSTAIN_RATE:  sus_rate = val;
			REG_RELEASE_RATE:  rel_rate = val;
			REG_DEFAULT_ATTN:  dflt_attn = val[LevelW-1:0];
			default: ;
		endcase
	endtask

	// Registers change only with nothing in flight.
	task automatic program_envelope(input logic [RateW-1:0] a, input logic [RateW-1:0] d,
			input logic [LevelW-1:0] sl, input logic [RateW-1:0] sr,
			input logic [RateW-1:0] rr, input logic [LevelW-1:0] da);
		drain_results();
		cfg_write(REG_ATTACK_RATE, a);
		cfg_write(REG_DECAY_RATE, d);
		cfg_write(REG_SUSTAIN_LEVEL, {4'd0, sl});
		cfg_write(REG_SUSTAIN_RATE, sr);
		cfg_write(REG_RELEASE_RATE, rr);
		cfg_write(REG_DEFAULT_ATTN, {4'd0, da});
		cfg_valid <= 1'b0;
	endtask

	// Mostly short rates so envelopes run through all phases within a phase.
	function automatic logic [RateW-1:0] pick_rate();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r <= 7) return RateW'($urandom_range(1, 3));
		if (r == 8) return RateW'($urandom_range(4, 20));
		return RateW'($urandom_range(0, 255));
	endfunction

	initial begin
		int               counted;
		int               ticks_left;
		int               r;
		logic             held;
		logic [OpW-1:0]   op;
		env_result_t      none;
		none = '{4'd0, 1'b0, PH_IDLE};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NumDirected; i++) begin
			if (i == DirGroupB) begin
				program_envelope(8'd0, 8'd1, 4'd7, 8'd1, 8'd1, 4'd10);
				send_idle_pct = 7;
				recv_stall_pct = 7;
			end
			push_event(dir_rows[i].op, dir_rows[i].attn, dir_rows[i].ud, dir_rows[i].typed,
				dir_rows[i].want);
		end

		for (int p = 0; p < NumPhases; p++) begin
			if (p == 0) program_envelope(8'd255, 8'd255, 4'd15, 8'd255, 8'd255, 4'd15);
			else if (p == 1) program_envelope(8'd0, 8'd0, 4'd0, 8'd0, 8'd0, 4'd15);
			else if (p == 5) program_envelope(8'd1, 8'd1, 4'd0, 8'd1, 8'd1, 4'd8);
			else program_envelope(pick_rate(), pick_rate(), LevelW'($urandom_range(0, 15)),
				pick_rate(), pick_rate(), LevelW'($urandom_range(0, 15)));
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			counted = 0;
			ticks_left = 0;
			held = 1'b0;
			// Note on, a run of ticks, note off, a run of ticks; some noise mixed in.
			while (counted < EventsPerPhase) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					op = OpW'($urandom_range(0, 3));
				end else if (ticks_left == 0) begin
					op = held ? OP_NOTE_OFF : OP_NOTE_ON;
					held = !held;
					ticks_left = $urandom_range(0, held ? 60 : 30);
				end else begin
					op = OP_TICK;
					ticks_left--;
				end
				push_event(op, LevelW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 1'b0,
					none);
				if (op != OpUnused) counted++;
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("adsr_attenuation_envelope_tb passed");
		end else begin
			$display("adsr_attenuation_envelope_tb failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/adsr_env_pkg.sv
hw/rtl/adsr_attenuation_envelope.sv
hw/rtl/adsr_env_chk.sv
sim/adsr_attenuation_envelope_tb.sv
